// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix expression evaluator: command and
// status codes, field widths and the request bundle of the arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 8;

  // Stream word widths, rounded up to whole bytes
  localparam int unsigned IN_W      = CMD_W + DATA_W;
  localparam int unsigned IN_TW     = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W     = STATUS_W + DATA_W + COUNT_W;
  localparam int unsigned OUT_TW    = ((OUT_W + 7) / 8) * 8;

  // Iteration counter of the shared unit
  localparam int unsigned LOOP_W    = $clog2(DATA_W);

  // Default stack depth
  localparam int unsigned STACK_DEPTH_DEF = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_FINISH = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_FULL    = 3'd3,
    ST_COUNT   = 3'd4
  } status_e;

  // Start request to the arithmetic unit
  typedef struct packed {
    logic start;
    cmd_e op;
  } alu_req_t;

endpackage

// File: rtl/rpn_stack.sv
// ----------------------------------------------------------------------------
// rpn_stack
// Operand stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpn_stack #(
  parameter int unsigned Depth = rpn_pkg::STACK_DEPTH_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [rpn_pkg::DATA_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [rpn_pkg::DATA_W-1:0] rd_data_o
);

  logic [rpn_pkg::DATA_W-1:0] mem [Depth];
  logic [rpn_pkg::DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative arithmetic unit built around one shared 32-bit adder. Add and
// subtract take one pass, multiply is shift-and-add over 32 passes, divide is
// restoring division on magnitudes with sign fix-up before and after.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpn_pkg::alu_req_t          req_i,
  input  logic [rpn_pkg::DATA_W-1:0] a_i,
  input  logic [rpn_pkg::DATA_W-1:0] b_i,
  output logic                       done_o,
  output logic [rpn_pkg::DATA_W-1:0] result_o
);

  localparam int unsigned W = rpn_pkg::DATA_W;

  typedef enum logic [5:0] {
    A_IDLE   = 6'b000001,
    A_ADDSUB = 6'b000010,
    A_NEGA   = 6'b000100,
    A_NEGB   = 6'b001000,
    A_LOOP   = 6'b010000,
    A_FIX    = 6'b100000
  } alu_state_e;

  alu_state_e state_q, state_d;
  logic       done_q, done_d;

  logic [W-1:0]              opa_q, opb_q, acc_q, res_q;
  logic [rpn_pkg::LOOP_W-1:0] cnt_q;
  logic                      neg_q;
  rpn_pkg::cmd_e             op_q;

  logic [W-1:0] add_x, add_y;
  logic         add_sub;
  logic [W:0]   add_sum;
  logic         last_iter;

  // shared adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      A_ADDSUB: begin
        add_x   = opa_q;
        add_y   = opb_q;
        add_sub = (op_q == rpn_pkg::CMD_SUB);
      end
      A_NEGA: begin
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      A_NEGB: begin
        add_y   = opb_q;
        add_sub = 1'b1;
      end
      A_LOOP: begin
        if (op_q == rpn_pkg::CMD_MUL) begin
          add_x = acc_q;
          add_y = opb_q[0] ? opa_q : '0;
        end else begin
          // trial subtract of divisor from shifted remainder
          add_x   = {acc_q[W-2:0], opa_q[W-1]};
          add_y   = opb_q;
          add_sub = 1'b1;
        end
      end
      A_FIX: begin
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // carry out set on subtract means no borrow
  assign add_sum   = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + {{W{1'b0}}, add_sub};
  assign last_iter = (cnt_q == rpn_pkg::LOOP_W'(W - 1));

  // sequencer
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            rpn_pkg::CMD_DIV: state_d = A_NEGA;
            rpn_pkg::CMD_MUL: state_d = A_LOOP;
            default:          state_d = A_ADDSUB;
          endcase
        end
      end
      A_ADDSUB: begin
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_NEGA: state_d = A_NEGB;
      A_NEGB: state_d = A_LOOP;
      A_LOOP: begin
        if (last_iter) begin
          if (op_q == rpn_pkg::CMD_MUL) begin
            done_d  = 1'b1;
            state_d = A_IDLE;
          end else begin
            state_d = A_FIX;
          end
        end
      end
      A_FIX: begin
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          opa_q <= a_i;
          opb_q <= b_i;
          op_q  <= req_i.op;
          acc_q <= '0;
          cnt_q <= '0;
          neg_q <= a_i[W-1] ^ b_i[W-1];
        end
      end
      A_ADDSUB: res_q <= add_sum[W-1:0];
      A_NEGA: begin
        if (opa_q[W-1]) begin
          opa_q <= add_sum[W-1:0];
        end
      end
      A_NEGB: begin
        if (opb_q[W-1]) begin
          opb_q <= add_sum[W-1:0];
        end
      end
      A_LOOP: begin
        cnt_q <= cnt_q + rpn_pkg::LOOP_W'(1);
        if (op_q == rpn_pkg::CMD_MUL) begin
          acc_q <= add_sum[W-1:0];
          opa_q <= {opa_q[W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[W-1:1]};
          if (last_iter) begin
            res_q <= add_sum[W-1:0];
          end
        end else begin
          acc_q <= add_sum[W] ? add_sum[W-1:0] : add_x;
          opa_q <= {opa_q[W-2:0], add_sum[W]};
        end
      end
      A_FIX: res_q <= neg_q ? add_sum[W-1:0] : opa_q;
      default: begin
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/rpn_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// Postfix integer expression evaluator. Each input word is one token; each
// token produces exactly one output word with status, value and stack count.
//
//   channel  | dir | tdata fields (low bit first)
//   s_axis   | in  | command[2:0], operand_value[34:3], pad to 40
//   m_axis   | out | status[2:0], result_value[34:3], stack_count[42:35], pad
//
// Push, unused codes and tokens that fail their count check go straight to
// the result; the others first read the stack, and arithmetic commands then
// run the arithmetic unit unless dividing by zero. Multiply and divide run
// the 32 passes of its shared adder; the two stack reads take turns on the
// single read port. One token is in flight at a time; the result sits in
// an output register so a stalled consumer only holds the next token's
// commit. Reset empties the stack; stack contents are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top #(
  parameter int unsigned StackDepth = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command[2:0], operand_value[34:3]
  input  logic [rpn_pkg::IN_TW-1:0]  s_axis_tdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // status[2:0], result_value[34:3], stack_count[42:35]
  output logic [rpn_pkg::OUT_TW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i
);

  localparam int unsigned W     = rpn_pkg::DATA_W;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDB  = 6'b000010,
    S_RDA  = 6'b000100,
    S_LOAD = 6'b001000,
    S_EXEC = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               m_valid_q, m_valid_d;

  // pending result of the current token
  rpn_pkg::cmd_e      cmd_q, cmd_d;
  rpn_pkg::status_e   pst_q, pst_d;
  logic [W-1:0]       pval_q, pval_d;
  logic [CntW-1:0]    pcnt_q, pcnt_d;
  logic [CntW-1:0]    ncnt_q, ncnt_d;
  logic               wr_q, wr_d;
  logic [AddrW-1:0]   wr_addr_q, wr_addr_d;
  logic [W-1:0]       b_q, b_d;

  // output register
  rpn_pkg::status_e          out_st_q;
  logic [W-1:0]              out_val_q;
  logic [rpn_pkg::COUNT_W-1:0] out_cnt_q, pcnt8;

  logic                s_acc, out_free, commit;
  rpn_pkg::cmd_e       in_cmd;
  logic [W-1:0]        in_val;
  logic [CntW-1:0]     cnt_m1, cnt_m2;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [W-1:0]        rd_data;
  rpn_pkg::alu_req_t   alu_req;
  logic                alu_done;
  logic [W-1:0]        alu_res;

  assign in_cmd   = rpn_pkg::cmd_e'(s_axis_tdata_i[rpn_pkg::CMD_W-1:0]);
  assign in_val   = s_axis_tdata_i[rpn_pkg::IN_W-1:rpn_pkg::CMD_W];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign commit   = (state_q == S_DONE) && out_free;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);

  // stack read: top entry first, then the one below
  assign rd_en   = (state_q == S_RDB) || (state_q == S_RDA);
  assign rd_addr = (state_q == S_RDB) ? cnt_m1[AddrW-1:0] : cnt_m2[AddrW-1:0];

  assign alu_req.start = (state_q == S_LOAD) &&
                         !((cmd_q == rpn_pkg::CMD_DIV) && (b_q == '0));
  assign alu_req.op    = cmd_q;

  // token sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    pst_d     = pst_q;
    pval_d    = pval_q;
    pcnt_d    = pcnt_q;
    ncnt_d    = ncnt_q;
    wr_d      = wr_q;
    wr_addr_d = wr_addr_q;
    b_d       = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          cmd_d     = in_cmd;
          pst_d     = rpn_pkg::ST_OK;
          pval_d    = '0;
          wr_d      = 1'b0;
          wr_addr_d = count_q[AddrW-1:0];
          state_d   = S_DONE;
          unique case (in_cmd)
            rpn_pkg::CMD_PUSH: begin
              if (count_q == CntW'(StackDepth)) begin
                pst_d  = rpn_pkg::ST_FULL;
                pcnt_d = '0;
                ncnt_d = '0;
              end else begin
                pval_d = in_val;
                pcnt_d = count_q + CntW'(1);
                ncnt_d = count_q + CntW'(1);
                wr_d   = 1'b1;
              end
            end
            rpn_pkg::CMD_FINISH: begin
              ncnt_d = '0;
              pcnt_d = count_q;
              if (count_q == CntW'(1)) begin
                state_d = S_RDB;
              end else begin
                pst_d = rpn_pkg::ST_COUNT;
              end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
            rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
              if (count_q < CntW'(2)) begin
                pst_d  = rpn_pkg::ST_FEW;
                pcnt_d = '0;
                ncnt_d = '0;
              end else begin
                pcnt_d    = cnt_m1;
                ncnt_d    = cnt_m1;
                wr_d      = 1'b1;
                wr_addr_d = cnt_m2[AddrW-1:0];
                state_d   = S_RDB;
              end
            end
            default: begin
              // unused codes: report, stack untouched
              pcnt_d = count_q;
              ncnt_d = count_q;
            end
          endcase
        end
      end
      S_RDB: state_d = S_RDA;
      S_RDA: begin
        if (cmd_q == rpn_pkg::CMD_FINISH) begin
          pval_d  = rd_data;
          state_d = S_DONE;
        end else begin
          b_d     = rd_data;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (alu_req.start) begin
          state_d = S_EXEC;
        end else begin
          pst_d   = rpn_pkg::ST_DIVZERO;
          pcnt_d  = '0;
          ncnt_d  = '0;
          wr_d    = 1'b0;
          state_d = S_DONE;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          pval_d  = alu_res;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          count_d = ncnt_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pst_q     <= pst_d;
    pval_q    <= pval_d;
    pcnt_q    <= pcnt_d;
    ncnt_q    <= ncnt_d;
    wr_q      <= wr_d;
    wr_addr_q <= wr_addr_d;
    b_q       <= b_d;
    if (commit) begin
      out_st_q  <= pst_q;
      out_val_q <= pval_q;
      out_cnt_q <= pcnt8;
    end
  end

  // report count as 8 bits
  if (CntW >= rpn_pkg::COUNT_W) begin : g_cnt_trunc
    assign pcnt8 = pcnt_q[rpn_pkg::COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign pcnt8 = {{(rpn_pkg::COUNT_W - CntW){1'b0}}, pcnt_q};
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(rpn_pkg::OUT_TW - rpn_pkg::OUT_W){1'b0}},
                            out_cnt_q, out_val_q, out_st_q};

  rpn_stack #(
    .Depth (StackDepth),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (commit && wr_q),
    .wr_addr_i (wr_addr_q),
    .wr_data_i (pval_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (rd_data),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix expression evaluator. Tokens are sent
// through the input stream with random gaps. Each accepted token runs through
// an in-bench stack calculator, and every output word is compared field by
// field with the oldest predicted outcome. The output side stalls at random
// and holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes outside the defined set; the block treats them as no-ops
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned CALC_DEPTH  = rpn_pkg::STACK_DEPTH_DEF;
  localparam int unsigned TOKEN_GOAL  = 800;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_LEN    = 400;

  typedef struct {
    logic [rpn_pkg::CMD_W-1:0]  cmd;
    logic [rpn_pkg::DATA_W-1:0] operand;
  } token_t;

  typedef struct {
    rpn_pkg::status_e            status;
    logic [rpn_pkg::DATA_W-1:0]  value;
    logic [rpn_pkg::COUNT_W-1:0] depth;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  logic [rpn_pkg::IN_TW-1:0]  src_data  = '0;
  logic                       src_valid = 1'b0;
  logic                       s_axis_tready_o;
  logic [rpn_pkg::OUT_TW-1:0] m_axis_tdata_o;
  logic                       m_axis_tvalid_o;
  logic                       snk_ready = 1'b0;
  logic                       snk_hold;
  logic                       m_axis_tready_i;

  assign m_axis_tready_i = snk_ready & ~snk_hold;

  rpn_stack_evaluator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (src_data),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // Output word fields
  logic [rpn_pkg::STATUS_W-1:0] got_status;
  logic [rpn_pkg::DATA_W-1:0]   got_value;
  logic [rpn_pkg::COUNT_W-1:0]  got_depth;
  assign got_status = m_axis_tdata_o[rpn_pkg::STATUS_W-1:0];
  assign got_value  = m_axis_tdata_o[rpn_pkg::STATUS_W +: rpn_pkg::DATA_W];
  assign got_depth  = m_axis_tdata_o[rpn_pkg::STATUS_W+rpn_pkg::DATA_W +: rpn_pkg::COUNT_W];

  token_t   token_q[$];
  outcome_t outcome_q[$];
  int unsigned n_tokens;
  int unsigned err_cnt = 0;

  // Calculator state mirrored in the bench
  logic [rpn_pkg::DATA_W-1:0] calc_stack [CALC_DEPTH];
  int unsigned                calc_depth = 0;

  // Apply one token to the mirrored stack and return what the block must emit
  function automatic outcome_t eval_token(input token_t tk);
    outcome_t res;
    logic [rpn_pkg::DATA_W-1:0] lhs, rhs, acc;
    longint quo;
    res = '{status: rpn_pkg::ST_OK, value: '0, depth: '0};
    case (tk.cmd)
      rpn_pkg::CMD_PUSH: begin
        if (calc_depth >= CALC_DEPTH) begin
          calc_depth = 0;
          res.status = rpn_pkg::ST_FULL;
        end else begin
          calc_stack[calc_depth] = tk.operand;
          calc_depth++;
          res.value = tk.operand;
          res.depth = rpn_pkg::COUNT_W'(calc_depth);
        end
      end
      rpn_pkg::CMD_FINISH: begin
        res.depth = rpn_pkg::COUNT_W'(calc_depth);
        if (calc_depth == 1) res.value = calc_stack[0];
        else res.status = rpn_pkg::ST_COUNT;
        calc_depth = 0;
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (calc_depth < 2) begin
          calc_depth = 0;
          res.status = rpn_pkg::ST_FEW;
        end else begin
          rhs = calc_stack[calc_depth-1];
          lhs = calc_stack[calc_depth-2];
          acc = '0;
          case (tk.cmd)
            rpn_pkg::CMD_ADD: acc = lhs + rhs;
            rpn_pkg::CMD_SUB: acc = lhs - rhs;
            rpn_pkg::CMD_MUL: acc = lhs * rhs;
            default: begin
              // 64-bit divide so that the most negative value over -1 wraps
              if (rhs != '0) begin
                quo = longint'($signed(lhs)) / longint'($signed(rhs));
                acc = quo[rpn_pkg::DATA_W-1:0];
              end
            end
          endcase
          if (tk.cmd == rpn_pkg::CMD_DIV && rhs == '0) begin
            calc_depth = 0;
            res.status = rpn_pkg::ST_DIVZERO;
          end else begin
            calc_stack[calc_depth-2] = acc;
            calc_depth--;
            res.value = acc;
            res.depth = rpn_pkg::COUNT_W'(calc_depth);
          end
        end
      end
      default: res.depth = rpn_pkg::COUNT_W'(calc_depth);
    endcase
    return res;
  endfunction

  // Idle length: mostly short, sometimes long, none during a quiet stretch
  function automatic int unsigned draw_idle(input int unsigned quiet);
    int unsigned r;
    if (quiet != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [rpn_pkg::DATA_W-1:0] draw_operand();
    int unsigned r;
    logic [rpn_pkg::DATA_W-1:0] w;
    r = $urandom_range(0, 99);
    w = $urandom();
    if (r < 40) return w;
    if (r < 70) begin
      return rpn_pkg::DATA_W'($urandom_range(0, 32)) - rpn_pkg::DATA_W'(16);
    end
    if (r < 85) return {{16{w[15]}}, w[15:0]};
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic add_token(input logic [rpn_pkg::CMD_W-1:0] cmd,
                           input logic [rpn_pkg::DATA_W-1:0] operand);
    token_q.push_back('{cmd: cmd, operand: operand});
    if (cmd <= rpn_pkg::CMD_FINISH) n_tokens++;
  endtask

  function automatic logic [rpn_pkg::CMD_W-1:0] draw_op();
    return rpn_pkg::CMD_W'($urandom_range(int'(rpn_pkg::CMD_ADD), int'(rpn_pkg::CMD_DIV)));
  endfunction

  // One expression: pushes and operators with random content, mostly well formed
  task automatic gen_expr();
    int unsigned pushes;
    int unsigned live;
    pushes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    live = 0;
    while (pushes != 0 || live > 1) begin
      if ($urandom_range(0, 39) == 0) break;
      if (live >= 2 && (pushes == 0 || $urandom_range(0, 1) == 0)) begin
        add_token(draw_op(), $urandom());
        live--;
      end else begin
        add_token(rpn_pkg::CMD_PUSH, draw_operand());
        live++;
        pushes--;
      end
    end
    if ($urandom_range(0, 19) == 0) add_token(draw_op(), $urandom());
    add_token(rpn_pkg::CMD_FINISH, $urandom());
  endtask

  // Empty the stack, then fill it to the top
  task automatic fill_stack();
    add_token(rpn_pkg::CMD_FINISH, $urandom());
    repeat (CALC_DEPTH) add_token(rpn_pkg::CMD_PUSH, draw_operand());
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver
  token_t      src_token;
  int unsigned src_gap   = 0;
  int unsigned src_quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_data  <= '0;
      src_gap   <= 0;
      src_quiet <= 0;
    end else begin
      if (src_valid && s_axis_tready_o) outcome_q.push_back(eval_token(src_token));
      if (src_quiet != 0) src_quiet <= src_quiet - 1;
      else if ($urandom_range(0, 59) == 0) src_quiet <= $urandom_range(30, 120);
      // Bus slot is free: idle for the drawn gap, then offer the next word
      if (!src_valid || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_valid <= 1'b0;
          src_gap   <= src_gap - 1;
        end else if (token_q.size() != 0) begin
          src_token = token_q.pop_front();
          src_data  <= rpn_pkg::IN_TW'({src_token.operand, src_token.cmd});
          src_valid <= 1'b1;
          src_gap   <= draw_idle(src_quiet);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and random ready
  outcome_t    exp_word;
  int unsigned snk_stall = 0;
  int unsigned snk_quiet = 0;
  int unsigned words_out = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snk_ready <= 1'b0;
      snk_stall <= 0;
      snk_quiet <= 0;
      words_out <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        words_out <= words_out + 1;
        if (outcome_q.size() == 0) begin
          err_cnt++;
          $error("result word %h with no outcome pending", m_axis_tdata_o);
        end else begin
          exp_word = outcome_q.pop_front();
          if (got_status != exp_word.status) begin
            err_cnt++;
            $error("status: expected %0d, got %0d", exp_word.status, got_status);
          end
          if (got_value != exp_word.value) begin
            err_cnt++;
            $error("result_value: expected %h, got %h", exp_word.value, got_value);
          end
          if (got_depth != exp_word.depth) begin
            err_cnt++;
            $error("stack_count: expected %0d, got %0d", exp_word.depth, got_depth);
          end
        end
      end
      if (snk_quiet != 0) snk_quiet <= snk_quiet - 1;
      else if ($urandom_range(0, 79) == 0) snk_quiet <= $urandom_range(30, 150);
      if (snk_stall != 0) begin
        snk_ready <= 1'b0;
        snk_stall <= snk_stall - 1;
      end else begin
        snk_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) snk_stall <= draw_idle(snk_quiet);
      end
    end
  end

  // One long receiver hold-off so the block backs up into its input
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_out >= HOLD_AFTER) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign snk_hold = (hold_left != 0);

  // Watchdog
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus and end of test
  logic deep_fill_done;
  logic overflow_done;

  initial begin
    rst_ni = 1'b0;
    n_tokens = 0;
    deep_fill_done = 1'b0;
    overflow_done = 1'b0;

    // Directed: empty-stack errors, wraparound, division corners, bad counts
    add_token(rpn_pkg::CMD_FINISH, $urandom());
    add_token(rpn_pkg::CMD_ADD, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'd7);
    add_token(rpn_pkg::CMD_SUB, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'h7FFF_FFFF);
    add_token(rpn_pkg::CMD_PUSH, 32'h0000_0001);
    add_token(rpn_pkg::CMD_ADD, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'hFFFF_FFFF);
    add_token(rpn_pkg::CMD_DIV, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'h8000_0000);
    add_token(rpn_pkg::CMD_MUL, $urandom());
    add_token(rpn_pkg::CMD_FINISH, $urandom());
    add_token(rpn_pkg::CMD_PUSH, -32'sd7);
    add_token(rpn_pkg::CMD_PUSH, 32'd2);
    add_token(rpn_pkg::CMD_DIV, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'h0000_0000);
    add_token(rpn_pkg::CMD_DIV, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'd5);
    add_token(rpn_pkg::CMD_PUSH, 32'd9);
    add_token(rpn_pkg::CMD_SUB, $urandom());
    add_token(rpn_pkg::CMD_PUSH, 32'd3);
    add_token(CMD_SPARE_LO, $urandom());
    add_token(CMD_SPARE_HI, 32'hFFFF_FFFF);
    add_token(rpn_pkg::CMD_FINISH, $urandom());

    // Random expressions with some noise; one full-depth finish and one overflow
    n_tokens = 0;
    while (n_tokens < TOKEN_GOAL) begin
      if (!deep_fill_done && n_tokens > 200) begin
        fill_stack();
        add_token(rpn_pkg::CMD_FINISH, $urandom());
        deep_fill_done = 1'b1;
      end else if (!overflow_done && n_tokens > 500) begin
        fill_stack();
        add_token(rpn_pkg::CMD_PUSH, draw_operand());
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          add_token(rpn_pkg::CMD_W'($urandom_range(0, 7)), $urandom());
        end
      end else begin
        gen_expr();
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (token_q.size() != 0 || src_valid) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0 && outcome_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rpn_pkg.sv
rtl/rpn_stack.sv
rtl/rpn_alu.sv
rtl/rpn_stack_evaluator_top.sv
verif/testbench.sv
